### sv/slx_pkg.sv
// Shared types, character codes and character-class functions for the shell line lexer.
package slx_pkg;

    localparam int RES_MAX = 3;

    typedef enum logic [2:0] {
        KIND_WORD  = 3'd0,
        KIND_PIPE  = 3'd1,
        KIND_RIN   = 3'd2,
        KIND_ROUT  = 3'd3,
        KIND_APP   = 3'd4,
        KIND_VAR   = 3'd5,
        KIND_VEXIT = 3'd6,
        KIND_VPID  = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_WORD   = 5'b00010,
        MODE_VAR    = 5'b00100,
        MODE_GT     = 5'b01000,
        MODE_DOLLAR = 5'b10000
    } mode_t;

    typedef logic [1:0] rcnt_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       has;
        logic       tend;
        logic       sq;
        logic       dq;
        logic       last;
    } res_t;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [7:0] v, input logic has,
                                    input logic tend, input logic sq, input logic dq);
        res_t r;
        r.kind  = k;
        r.value = has ? v : 8'd0;
        r.has   = has;
        r.tend  = tend;
        r.sq    = sq;
        r.dq    = dq;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

### sv/slx_core.sv
// Lexer state registers and the single-pass step logic producing up to three results.
module slx_core
    import slx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] char_in,
    input  logic       char_valid,
    input  logic       line_end,
    output res_t       res_o [RES_MAX],
    output rcnt_t      cnt_o
);

    mode_t mode_reg, mode_next;
    logic  isq_reg, isq_next;
    logic  idq_reg, idq_next;
    logic  ssq_reg, ssq_next;
    logic  sdq_reg, sdq_next;

    always_comb begin : step
        mode_t      m;
        logic       isq, idq, ssq, sdq, from_idle;
        rcnt_t      n;
        res_t       r [RES_MAX];
        logic [7:0] c;

        m         = mode_reg;
        isq       = isq_reg;
        idq       = idq_reg;
        ssq       = ssq_reg;
        sdq       = sdq_reg;
        from_idle = 1'b0;
        n         = '0;
        c         = char_in;
        for (int i = 0; i < RES_MAX; i++) r[i] = '0;

        if (char_valid) begin
            case (mode_reg)
                MODE_WORD: begin
                    if (c == CH_SQUOTE && !idq) begin
                        isq = !isq;
                        ssq = 1'b1;
                    end else if (c == CH_DQUOTE && !isq) begin
                        idq = !idq;
                        sdq = 1'b1;
                    end
                    if (!isq && !idq && (is_ws(c) || is_delim(c))) begin
                        r[n] = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b1, ssq, sdq);
                        n = n + 2'd1;
                        isq = 1'b0;
                        idq = 1'b0;
                        ssq = 1'b0;
                        sdq = 1'b0;
                        from_idle = 1'b1;
                    end else begin
                        r[n] = mk_res(KIND_WORD, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        n = n + 2'd1;
                    end
                end
                MODE_VAR: begin
                    if (is_name(c)) begin
                        r[n] = mk_res(KIND_VAR, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        n = n + 2'd1;
                    end else begin
                        r[n] = mk_res(KIND_VAR, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                        n = n + 2'd1;
                        from_idle = 1'b1;
                    end
                end
                MODE_GT: begin
                    if (c == CH_GT) begin
                        r[n] = mk_res(KIND_APP, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                        n = n + 2'd1;
                        m = MODE_IDLE;
                    end else begin
                        r[n] = mk_res(KIND_ROUT, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                        n = n + 2'd1;
                        from_idle = 1'b1;
                    end
                end
                MODE_DOLLAR: begin
                    if (c == CH_QMARK || c == CH_DOLLAR) begin
                        r[0] = mk_res((c == CH_QMARK) ? KIND_VEXIT : KIND_VPID,
                                      c, 1'b1, 1'b0, 1'b0, 1'b0);
                        r[1] = mk_res((c == CH_QMARK) ? KIND_VEXIT : KIND_VPID,
                                      8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                        n = 2'd2;
                        m = MODE_IDLE;
                    end else if (is_name(c)) begin
                        r[n] = mk_res(KIND_VAR, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        n = n + 2'd1;
                        m = MODE_VAR;
                    end else begin
                        from_idle = 1'b1;
                    end
                end
                default: from_idle = 1'b1;
            endcase

            // byte that closes a token, follows a bare dollar or arrives idle is lexed from idle
            if (from_idle) begin
                m = MODE_IDLE;
                if (is_ws(c)) begin
                    m = MODE_IDLE;
                end else if (c == CH_PIPE) begin
                    r[n] = mk_res(KIND_PIPE, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                    n = n + 2'd1;
                end else if (c == CH_LT) begin
                    r[n] = mk_res(KIND_RIN, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                    n = n + 2'd1;
                end else if (c == CH_GT) begin
                    m = MODE_GT;
                end else if (c == CH_DOLLAR) begin
                    m = MODE_DOLLAR;
                end else begin
                    // new word; its first byte can never end it
                    m   = MODE_WORD;
                    isq = (c == CH_SQUOTE);
                    idq = (c == CH_DQUOTE);
                    ssq = (c == CH_SQUOTE);
                    sdq = (c == CH_DQUOTE);
                    r[n] = mk_res(KIND_WORD, c, 1'b1, 1'b0, 1'b0, 1'b0);
                    n = n + 2'd1;
                end
            end
        end

        if (line_end) begin
            if (n != 2'd3) begin
                if (m == MODE_WORD) begin
                    r[n] = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b1, ssq, sdq);
                    n = n + 2'd1;
                end else if (m == MODE_VAR) begin
                    r[n] = mk_res(KIND_VAR, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                    n = n + 2'd1;
                end else if (m == MODE_GT) begin
                    r[n] = mk_res(KIND_ROUT, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                    n = n + 2'd1;
                end
            end
            m   = MODE_IDLE;
            isq = 1'b0;
            idq = 1'b0;
            ssq = 1'b0;
            sdq = 1'b0;
        end

        if (n != 2'd0) r[n - 2'd1].last = 1'b1;

        mode_next = m;
        isq_next  = isq;
        idq_next  = idq;
        ssq_next  = ssq;
        sdq_next  = sdq;
        res_o     = r;
        cnt_o     = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            isq_reg  <= 1'b0;
            idq_reg  <= 1'b0;
            ssq_reg  <= 1'b0;
            sdq_reg  <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            isq_reg  <= isq_next;
            idq_reg  <= idq_next;
            ssq_reg  <= ssq_next;
            sdq_reg  <= sdq_next;
        end
    end

endmodule

### sv/slx_outq.sv
// Result register bank: holds the results of one request and hands them out one per cycle while out_ready is high.
module slx_outq
    import slx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  load,
    input  res_t  res_i [RES_MAX],
    input  rcnt_t cnt_i,
    output logic  free,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    res_t  slot_reg [RES_MAX];
    rcnt_t cnt_reg;
    logic  pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = slot_reg[0];
    assign pop       = out_valid && out_ready;
    // a new request fits once the bank is empty or its final result leaves now
    assign free      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= cnt_i;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res_i;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop))
        else $error("result bank overwritten while holding results");

    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> slot_reg[0].last)
        else $error("final result of a request lacks its last flag");

    a_early_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 || cnt_reg == 2'd3) |-> !slot_reg[0].last)
        else $error("last flag on a result that is not the final one");

    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_res.tend) |-> !out_res.has)
        else $error("token end marker carries a byte");

endmodule

### sv/shell_line_lexer.sv
// Top level of the shell line lexer: stream ports, step logic and result bank.
//
//  channel | dir | ports                          | contents
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | at most one command-line byte per request
//  m_      | out | m_tvalid m_tready m_tdata m_tuser m_tlast | one token byte or end marker
//
// A request is lexed in the cycle it is accepted; its results (0 to 3) appear from the
// next cycle on, one per cycle from the result bank while m_tready is high.
// Requests with at most one result flow at one per cycle while m_tready is high; a request
// with more results holds s_tready low while the bank drains.
// A stall on m_ holds the bank; s_tready stays low while it holds results and its final
// result is not leaving.
// aresetn is synchronous; after it the lexer is idle between tokens and the bank is empty.
module shell_line_lexer
    import slx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_in, [8] char_valid, [15:9] zero
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value_byte, [8] has_byte, [9] single_quoted,
                                   // [10] double_quoted, [11] last_of_item, [15:12] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // token_end
);

    logic  take;
    logic  free;
    res_t  step_res [RES_MAX];
    rcnt_t step_cnt;
    res_t  out_res;

    assign s_tready = free;
    assign take     = s_tvalid && free;

    slx_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .char_in    (s_tdata[7:0]),
        .char_valid (s_tdata[8]),
        .line_end   (s_tlast),
        .res_o      (step_res),
        .cnt_o      (step_cnt)
    );

    slx_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take && (step_cnt != 2'd0)),
        .res_i     (step_res),
        .cnt_i     (step_cnt),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'd0, out_res.last, out_res.dq, out_res.sq, out_res.has, out_res.value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.tend;

endmodule

### dv/lexer_checker.sv
// Checker for the shell line lexer: predicts the token parts of each request and compares.
module lexer_checker
    import slx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_in, [8] char_valid, [15:9] zero
    input  logic        s_tlast,   // line_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] value_byte, [8] has_byte, [9] single_quoted,
                                   // [10] double_quoted, [11] last_of_item, [15:12] zero
    input  logic [2:0]  m_tuser,   // [2:0] token_kind
    input  logic        m_tlast,   // token_end
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output int          tokens_seen,
    output logic [7:0]  kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PRINT_CAP  = 40;
    localparam logic [7:0] UNDERSCORE = 8'h5F;

    // lexer state as predicted
    mode_t lx_mode;
    logic  in_sq, in_dq, had_sq, had_dq;

    res_t token_parts_due[$];
    res_t step_parts[$];

    function automatic logic blank(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], CH_SPACE};
    endfunction

    function automatic logic splits(input logic [7:0] c);
        return c inside {CH_PIPE, CH_LT, CH_GT};
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        // a-z, A-Z, 0-9, underscore
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], UNDERSCORE};
    endfunction

    task automatic add_part(input kind_t k, input logic [7:0] v, input logic has_b,
                            input logic tend_b, input logic sq_b, input logic dq_b);
        res_t r;
        r       = '0;
        r.kind  = k;
        r.value = has_b ? v : 8'h00;
        r.has   = has_b;
        r.tend  = tend_b;
        r.sq    = sq_b;
        r.dq    = dq_b;
        step_parts.push_back(r);
    endtask

    task automatic clear_quotes();
        in_sq  = 1'b0;
        in_dq  = 1'b0;
        had_sq = 1'b0;
        had_dq = 1'b0;
    endtask

    task automatic close_word();
        add_part(KIND_WORD, 8'h00, 1'b0, 1'b1, had_sq, had_dq);
        clear_quotes();
        lx_mode = MODE_IDLE;
    endtask

    // A byte that ends a token is run again from idle, hence the loop.
    task automatic lex_char(input logic [7:0] c);
        logic again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (lx_mode)
                MODE_WORD: begin
                    if (c == CH_SQUOTE && !in_dq) begin
                        in_sq  = !in_sq;
                        had_sq = 1'b1;
                    end else if (c == CH_DQUOTE && !in_sq) begin
                        in_dq  = !in_dq;
                        had_dq = 1'b1;
                    end
                    if (!in_sq && !in_dq && (blank(c) || splits(c))) begin
                        close_word();
                        again = 1'b1;
                    end else begin
                        add_part(KIND_WORD, c, 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                end
                MODE_VAR: begin
                    if (name_char(c)) begin
                        add_part(KIND_VAR, c, 1'b1, 1'b0, 1'b0, 1'b0);
                    end else begin
                        add_part(KIND_VAR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                end
                MODE_GT: begin
                    lx_mode = MODE_IDLE;
                    if (c == CH_GT) begin
                        add_part(KIND_APP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else begin
                        add_part(KIND_ROUT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                        again = 1'b1;
                    end
                end
                MODE_DOLLAR: begin
                    lx_mode = MODE_IDLE;
                    if (c == CH_QMARK) begin
                        add_part(KIND_VEXIT, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        add_part(KIND_VEXIT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else if (c == CH_DOLLAR) begin
                        add_part(KIND_VPID, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        add_part(KIND_VPID, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else if (name_char(c)) begin
                        add_part(KIND_VAR, c, 1'b1, 1'b0, 1'b0, 1'b0);
                        lx_mode = MODE_VAR;
                    end else begin
                        again = 1'b1;  // bare dollar: drop it, lex the byte
                    end
                end
                default: begin
                    if (blank(c)) begin
                    end else if (c == CH_PIPE) begin
                        add_part(KIND_PIPE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else if (c == CH_LT) begin
                        add_part(KIND_RIN, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else if (c == CH_GT) begin
                        lx_mode = MODE_GT;
                    end else if (c == CH_DOLLAR) begin
                        lx_mode = MODE_DOLLAR;
                    end else begin
                        clear_quotes();
                        lx_mode = MODE_WORD;
                        again   = 1'b1;
                    end
                end
            endcase
        end
    endtask

    task automatic lex_request(input logic [7:0] c, input logic has_char, input logic eol);
        res_t r;
        step_parts.delete();
        if (has_char)
            lex_char(c);
        if (eol) begin
            case (lx_mode)
                MODE_WORD:   close_word();
                MODE_VAR:    add_part(KIND_VAR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                MODE_GT:     add_part(KIND_ROUT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                default:     ;
            endcase
            lx_mode = MODE_IDLE;
            clear_quotes();
        end
        for (int i = 0; i < step_parts.size(); i++) begin
            r      = step_parts[i];
            r.last = (i == step_parts.size() - 1);
            token_parts_due.push_back(r);
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] lexer mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_part();
        res_t want;
        results_seen++;
        if (m_tlast) begin
            tokens_seen++;
            kinds_seen[m_tuser] = 1'b1;
        end
        if (token_parts_due.size() == 0) begin
            report("result with none due, kind", m_tuser, 0);
            return;
        end
        want = token_parts_due.pop_front();
        if (m_tuser != want.kind)        report("token_kind", m_tuser, want.kind);
        if (m_tdata[7:0] != want.value)  report("value_byte", m_tdata[7:0], want.value);
        if (m_tdata[8] != want.has)      report("has_byte", m_tdata[8], want.has);
        if (m_tlast != want.tend)        report("token_end", m_tlast, want.tend);
        if (m_tdata[9] != want.sq)       report("single_quoted", m_tdata[9], want.sq);
        if (m_tdata[10] != want.dq)      report("double_quoted", m_tdata[10], want.dq);
        if (m_tdata[11] != want.last)    report("last_of_item", m_tdata[11], want.last);
        if (m_tdata[15:12] != 4'd0)      report("tdata pad", m_tdata[15:12], 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            token_parts_due.delete();
            lx_mode = MODE_IDLE;
            clear_quotes();
            mismatches   = 0;
            results_seen = 0;
            tokens_seen  = 0;
            kinds_seen   = '0;
        end else begin
            // results seen at this edge belong to requests taken at earlier edges
            if (m_tvalid && m_tready)
                check_part();
            if (s_tvalid && s_tready)
                lex_request(s_tdata[7:0], s_tdata[8], s_tlast);
        end
        outstanding <= token_parts_due.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the shell line lexer: stimulus, flow control and verdict.
module tb;
    import slx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RANDOM_REQS = 480;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 16;
    localparam int         PAUSE_EVERY = 120;
    localparam logic [7:0] UNDERSCORE  = 8'h5F;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       eol;
    } char_req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic        calm = 1'b0;
    int          mismatches, outstanding, results_seen, tokens_seen;
    logic [7:0]  kinds_seen;

    char_req_t   line_reqs[$];
    int          active_reqs = 0;   // requests that carry a byte or a line end

    shell_line_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lexer_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .tokens_seen  (tokens_seen),
        .kinds_seen   (kinds_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 31);
    end

    task automatic push_req(input logic [7:0] c, input logic has_char, input logic eol);
        char_req_t r;
        r.ch    = c;
        r.valid = has_char;
        r.eol   = eol;
        line_reqs.push_back(r);
        if (has_char || eol)
            active_reqs++;
    endtask

    function automatic logic [7:0] name_pick();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h61, 8'h7A));
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            2:       return 8'($urandom_range(8'h30, 8'h39));
            default: return UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] word_pick();
        case ($urandom_range(0, 9))
            0, 1, 2: return name_pick();
            3:       return $urandom_range(0, 1) ? CH_DOLLAR : CH_QMARK;
            4:       return 8'($urandom_range(8'h80, 8'hFF));
            5:       return 8'($urandom_range(0, 8));   // zero byte, low controls
            6:       return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // One command line: tokens with random spacing, closed by a line end.
    task automatic add_line();
        char_req_t  tail;
        logic [7:0] q;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0:       ;  // tokens abut
                1:       push_req(CH_SPACE, 1'b1, 1'b0);
                2:       push_req(8'($urandom_range(9, 13)), 1'b1, 1'b0);
                default: begin
                    push_req(CH_SPACE, 1'b1, 1'b0);
                    push_req(CH_TAB, 1'b1, 1'b0);
                end
            endcase
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 5)) push_req(word_pick(), 1'b1, 1'b0);
                    if ($urandom_range(0, 2) == 0) begin
                        // quoted run holding blanks and delimiters
                        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        push_req(q, 1'b1, 1'b0);
                        repeat ($urandom_range(0, 4)) begin
                            case ($urandom_range(0, 4))
                                0:       push_req(CH_SPACE, 1'b1, 1'b0);
                                1:       push_req(CH_PIPE, 1'b1, 1'b0);
                                2:       push_req(CH_GT, 1'b1, 1'b0);
                                3:       push_req(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE,
                                                  1'b1, 1'b0);
                                default: push_req(word_pick(), 1'b1, 1'b0);
                            endcase
                        end
                        if ($urandom_range(0, 5) != 0)
                            push_req(q, 1'b1, 1'b0);
                    end
                end
                5: push_req(CH_PIPE, 1'b1, 1'b0);
                6: push_req(CH_LT, 1'b1, 1'b0);
                7: push_req(CH_GT, 1'b1, 1'b0);
                8: begin
                    push_req(CH_GT, 1'b1, 1'b0);
                    push_req(CH_GT, 1'b1, 1'b0);
                end
                9, 10: begin
                    push_req(CH_DOLLAR, 1'b1, 1'b0);
                    repeat ($urandom_range(1, 4)) push_req(name_pick(), 1'b1, 1'b0);
                end
                default: begin
                    push_req(CH_DOLLAR, 1'b1, 1'b0);
                    case ($urandom_range(0, 2))
                        0:       push_req(CH_QMARK, 1'b1, 1'b0);
                        1:       push_req(CH_DOLLAR, 1'b1, 1'b0);
                        default: push_req(word_pick(), 1'b1, 1'b0);
                    endcase
                end
            endcase
        end
        if ($urandom_range(0, 1)) begin
            tail     = line_reqs.pop_back();
            tail.eol = 1'b1;
            line_reqs.push_back(tail);
        end else begin
            push_req(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial begin
        char_req_t r;
        int        n_dir;
        int        n_dir_active;
        int        n_sent;
        int        n_eol;
        int        calm_from;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        n_sent   = 0;
        n_eol    = 0;

        // directed lines
        push_req(8'h61, 1'b1, 1'b0);         // a
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h00, 1'b1, 1'b0);         // zero byte is a word byte
        push_req(CH_PIPE, 1'b1, 1'b0);       // ends word, then pipe
        push_req(CH_LT, 1'b1, 1'b0);
        push_req(CH_GT, 1'b1, 1'b0);
        push_req(CH_GT, 1'b1, 1'b0);         // append
        push_req(CH_GT, 1'b1, 1'b0);
        push_req(8'h78, 1'b1, 1'b0);         // x: redirect out, then word
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_SPACE, 1'b1, 1'b0);      // blank inside quotes
        push_req(CH_SQUOTE, 1'b1, 1'b0);     // literal inside double quotes
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_CR, 1'b1, 1'b0);
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(CH_QMARK, 1'b1, 1'b0);      // exit status
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(CH_DOLLAR, 1'b1, 1'b0);     // pid
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(UNDERSCORE, 1'b1, 1'b0);
        push_req(CH_PIPE, 1'b1, 1'b0);       // ends variable, then pipe
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(8'h25, 1'b1, 1'b0);         // %: bare dollar, word starts
        push_req(8'hA5, 1'b0, 1'b1);         // line end only, flushes word
        push_req(CH_GT, 1'b1, 1'b1);         // pending redirect at line end
        push_req(CH_DOLLAR, 1'b1, 1'b1);     // dollar at line end
        push_req(CH_SQUOTE, 1'b1, 1'b0);
        push_req(8'h62, 1'b1, 1'b1);         // unclosed quote flushed
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(8'h5A, 1'b1, 1'b1);         // variable at line end
        push_req(8'h5A, 1'b0, 1'b0);         // no byte, no line end
        n_dir        = line_reqs.size();
        n_dir_active = active_reqs;

        while (active_reqs - n_dir_active < RANDOM_REQS) begin
            if ($urandom_range(0, 99) < 15) begin
                // noise: raw bytes with random valid and line end flags
                repeat ($urandom_range(1, 8))
                    push_req(8'($urandom), $urandom_range(0, 3) != 0,
                             $urandom_range(0, 7) == 0);
            end else begin
                add_line();
            end
        end
        calm_from = n_dir + (line_reqs.size() - n_dir) / 2;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < line_reqs.size(); i++) begin
            calm <= (i >= calm_from && i < calm_from + 100);
            if (i >= n_dir && (i - n_dir) % PAUSE_EVERY == 0) begin
                // hold off until the lexer has drained
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end else if (!(i >= calm_from && i < calm_from + 100) &&
                         $urandom_range(0, 99) < 45) begin
                // one idle cycle before about 45 of 100 requests: ~31% idle cycles
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            r = line_reqs[i];
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, r.valid, r.ch};
            s_tlast  <= r.eol;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            n_sent++;
            if (r.eol)
                n_eol++;
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d requests (%0d directed) with %0d line ends",
                 n_sent, n_dir, n_eol);
        $display("checked %0d results in %0d tokens, token kinds seen %b",
                 results_seen, tokens_seen, kinds_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ends the run when no request moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request moved for %0d cycles, %0d results still due",
                 STALL_LIMIT, outstanding);
        $display("status: fail");
        $finish;
    end

endmodule
